FILE: sv/stpe_pkg.sv
package stpe_pkg;

  // Fixed field widths of the channels.
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_PIVOT = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_OPTIM = 3'd3;
  localparam logic [OP_W-1:0] OP_RATIO = 3'd4;
  localparam logic [OP_W-1:0] OP_FEAS  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ROW = 2'd1;
  localparam logic [1:0] ST_BAD_COL = 2'd2;
  localparam logic [1:0] ST_ZERO_PV = 2'd3;

  // Verdict codes.
  localparam logic [1:0] VD_NONE       = 2'd0;
  localparam logic [1:0] VD_FOUND      = 2'd1;
  localparam logic [1:0] VD_INFEASIBLE = 2'd2;

  // Configuration register indexes.
  localparam logic REG_VAR_COUNT = 1'b0;
  localparam logic REG_CON_COUNT = 1'b1;

  // Numerator sources for the shared divider.
  typedef enum logic [1:0] {
    NUM_RECIP,
    NUM_ROW,
    NUM_COL,
    NUM_GEN
  } num_sel_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic [IDX_W-1:0]  rd_row;
    logic [IDX_W-1:0]  rd_col;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_row;
    logic [IDX_W-1:0]  wr_col;
    logic              wr_from_div;
    logic [DATA_W-1:0] wr_val;
    logic              ld_d;
    logic              ld_s;
    logic              ld_r;
    logic              ld_c;
    logic              mul_sp;
    logic              mul_rc;
    logic              div_start;
    num_sel_t          num_sel;
    logic              ld_best;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic signed [DATA_W-1:0] rd_data;
    logic                     div_done;
    logic                     quo_lt_best;
  } sts_t;

endpackage

FILE: sv/stpe_div.sv
module stpe_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [64:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} dstate_t;

  dstate_t            state;
  logic signed [64:0] num_q;
  logic signed [31:0] den_q;
  logic               neg;
  logic [63:0]        nq;
  logic [31:0]        dm;
  logic [31:0]        rem;
  logic [5:0]         cnt;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic [64:0]        num_neg;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem, nq[63]};
    diff    = trial - {1'b0, dm};
    num_neg = -num_q;
  end

  // Sign-magnitude division, one quotient bit per cycle, then saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            num_q <= num;
            den_q <= den;
            state <= D_PREP;
          end
        end
        D_PREP: begin
          neg   <= num_q[64] ^ den_q[31];
          nq    <= num_q[64] ? num_neg[63:0] : num_q[63:0];
          dm    <= den_q[31] ? 32'(-den_q) : den_q;
          rem   <= '0;
          cnt   <= '0;
          state <= D_RUN;
        end
        D_RUN: begin
          if (!diff[32]) begin
            rem <= diff[31:0];
            nq  <= {nq[62:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            nq  <= {nq[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg) begin
            quo <= (nq > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-nq[31:0]);
          end else begin
            quo <= (nq > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : nq[31:0];
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/stpe_datapath.sv
module stpe_datapath #(
  parameter int MAX_VARS        = 16,
  parameter int MAX_CONSTRAINTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  stpe_pkg::cmd_t  cmd,
  output stpe_pkg::sts_t  sts
);

  localparam int COLS  = MAX_VARS + 1;
  localparam int ROWS  = MAX_CONSTRAINTS + 1;
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_q;
  logic signed [31:0] d_q, s_q, r_q, c_q, best;
  logic signed [63:0] prod_sp, prod_rc, prod;
  logic signed [31:0] mul_a, mul_b;
  logic signed [64:0] num, row_num, col_num;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               div_done;
  logic signed [31:0] quo;

  // Flat row-major addressing of the tableau.
  assign rd_addr = AW'(int'(cmd.rd_row) * COLS + int'(cmd.rd_col));
  assign wr_addr = AW'(int'(cmd.wr_row) * COLS + int'(cmd.wr_col));

  // Tableau memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_from_div ? quo : cmd.wr_val;
    end
    rd_q <= mem[rd_addr];
  end

  // Shared multiplier, either S*p or R*C.
  always_comb begin
    mul_a = cmd.mul_rc ? r_q : s_q;
    mul_b = cmd.mul_rc ? c_q : d_q;
    prod  = 64'(mul_a * mul_b);
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_d)    d_q     <= rd_q;
    if (cmd.ld_s)    s_q     <= rd_q;
    if (cmd.ld_r)    r_q     <= rd_q;
    if (cmd.ld_c)    c_q     <= rd_q;
    if (cmd.mul_sp)  prod_sp <= prod;
    if (cmd.mul_rc)  prod_rc <= prod;
    if (cmd.ld_best) best    <= quo;
  end

  // Numerator for the divider.
  always_comb begin
    row_num = {{17{r_q[31]}}, r_q, 16'h0000};
    col_num = -{{17{c_q[31]}}, c_q, 16'h0000};
    unique case (cmd.num_sel)
      stpe_pkg::NUM_RECIP: num = 65'sh1_0000_0000;
      stpe_pkg::NUM_ROW:   num = row_num;
      stpe_pkg::NUM_COL:   num = col_num;
      stpe_pkg::NUM_GEN:   num = {prod_sp[63], prod_sp} - {prod_rc[63], prod_rc};
      default:             num = '0;
    endcase
  end

  stpe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (d_q),
    .done  (div_done),
    .quo   (quo)
  );

  assign sts.rd_data     = rd_q;
  assign sts.div_done    = div_done;
  assign sts.quo_lt_best = (quo < best);

endmodule

FILE: sv/stpe_ctrl.sv
module stpe_ctrl #(
  parameter int MAX_VARS        = 16,
  parameter int MAX_CONSTRAINTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stpe_pkg::OP_W-1:0]     op,
  input  logic [stpe_pkg::IDX_W-1:0]    row_index,
  input  logic [stpe_pkg::IDX_W-1:0]    col_index,
  input  logic signed [31:0]            entry_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [1:0]                    verdict,
  output logic [stpe_pkg::IDX_W-1:0]    chosen_row,
  output logic [stpe_pkg::IDX_W-1:0]    chosen_col,
  output logic signed [31:0]            read_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [4:0]                    cfg_data,
  output stpe_pkg::cmd_t                cmd,
  input  stpe_pkg::sts_t                sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RD_WAIT,
    S_PV_CHK, S_PV_ROW, S_PV_C, S_PV_C2, S_PV_S, S_PV_S2, S_PV_R2,
    S_PV_M, S_PV_GEN, S_PV_RDIV, S_PV_DIV,
    S_OC_RD, S_OC_CHK,
    S_RT_E, S_RT_E2, S_RT_H, S_RT_H2, S_RT_GO, S_RT_DIV,
    S_FS_RD, S_FS_CHK, S_FS_CRD, S_FS_CCHK,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [stpe_pkg::OP_W-1:0]       op_q;
  logic [4:0]                      row_q, col_q, vc, cc, i_q, j_q, nrow;
  logic signed [31:0]              val_q;
  logic                            prow, found;
  logic [1:0]                      res_status, res_verdict;
  logic [4:0]                      res_row, res_col;
  logic signed [31:0]              res_data;
  logic                            rt_next;

  function automatic logic [4:0] clamp_count(input logic [4:0] v, input int hi);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (int'(v) > hi) r = 5'(hi);
    else r = v;
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);

  // Command decode per sequencer state.
  always_comb begin
    cmd             = '0;
    cmd.rd_row      = row_q;
    cmd.rd_col      = col_q;
    cmd.wr_row      = i_q;
    cmd.wr_col      = j_q;
    cmd.wr_val      = val_q;
    cmd.num_sel     = stpe_pkg::NUM_GEN;
    unique case (state)
      S_DISPATCH: begin
        cmd.wr_row = row_q;
        cmd.wr_col = col_q;
        cmd.wr_en  = (op_q == stpe_pkg::OP_WRITE) && (row_q <= cc) && (col_q <= vc);
      end
      S_PV_CHK:  cmd.ld_d = 1'b1;
      S_PV_C: begin
        cmd.rd_row = i_q;
        cmd.rd_col = col_q;
      end
      S_PV_C2:   cmd.ld_c = 1'b1;
      S_PV_S: begin
        cmd.rd_row    = i_q;
        cmd.rd_col    = j_q;
        cmd.div_start = (j_q == col_q);
        cmd.num_sel   = prow ? stpe_pkg::NUM_RECIP : stpe_pkg::NUM_COL;
      end
      S_PV_S2: begin
        cmd.rd_row = row_q;
        cmd.rd_col = j_q;
        cmd.ld_r   = prow;
        cmd.ld_s   = !prow;
      end
      S_PV_R2: begin
        cmd.ld_r   = 1'b1;
        cmd.mul_sp = 1'b1;
      end
      S_PV_M:    cmd.mul_rc = 1'b1;
      S_PV_GEN: begin
        cmd.div_start = 1'b1;
        cmd.num_sel   = stpe_pkg::NUM_GEN;
      end
      S_PV_RDIV, S_RT_GO: begin
        cmd.div_start = 1'b1;
        cmd.num_sel   = stpe_pkg::NUM_ROW;
      end
      S_PV_DIV: begin
        cmd.wr_en       = sts.div_done;
        cmd.wr_from_div = 1'b1;
      end
      S_OC_RD: begin
        cmd.rd_row = cc;
        cmd.rd_col = j_q;
      end
      S_RT_E: begin
        cmd.rd_row = i_q;
        cmd.rd_col = col_q;
      end
      S_RT_E2:   cmd.ld_d = 1'b1;
      S_RT_H, S_FS_RD: begin
        cmd.rd_row = i_q;
        cmd.rd_col = vc;
      end
      S_RT_H2:   cmd.ld_r = 1'b1;
      S_RT_DIV:  cmd.ld_best = sts.div_done && (!found || sts.quo_lt_best);
      S_FS_CRD: begin
        cmd.rd_row = nrow;
        cmd.rd_col = j_q;
      end
      default: ;
    endcase
  end

  // Ratio test and feasibility search move to the next row or finish.
  assign rt_next = (i_q == cc - 5'd1);

  // Sequencer state, loop counters, configuration and output beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vc        <= 5'd2;
      cc        <= 5'd1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == stpe_pkg::REG_VAR_COUNT) vc <= clamp_count(cfg_data, MAX_VARS);
        else cc <= clamp_count(cfg_data, MAX_CONSTRAINTS);
      end
      // A taken beat empties the output register unless a new result refills it.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q        <= op;
            row_q       <= row_index;
            col_q       <= col_index;
            val_q       <= entry_value;
            res_status  <= stpe_pkg::ST_OK;
            res_verdict <= stpe_pkg::VD_NONE;
            res_row     <= '0;
            res_col     <= '0;
            res_data    <= '0;
            i_q         <= '0;
            j_q         <= '0;
            found       <= 1'b0;
            prow        <= 1'b0;
            state       <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          priority case (op_q)
            stpe_pkg::OP_WRITE, stpe_pkg::OP_READ: begin
              if (row_q > cc) begin
                res_status <= stpe_pkg::ST_BAD_ROW;
                state      <= S_FINISH;
              end else if (col_q > vc) begin
                res_status <= stpe_pkg::ST_BAD_COL;
                state      <= S_FINISH;
              end else if (op_q == stpe_pkg::OP_READ) begin
                state <= S_RD_WAIT;
              end else begin
                state <= S_FINISH;
              end
            end
            stpe_pkg::OP_PIVOT: begin
              if (row_q >= cc) begin
                res_status <= stpe_pkg::ST_BAD_ROW;
                state      <= S_FINISH;
              end else if (col_q >= vc) begin
                res_status <= stpe_pkg::ST_BAD_COL;
                state      <= S_FINISH;
              end else begin
                state <= S_PV_CHK;
              end
            end
            stpe_pkg::OP_OPTIM: state <= S_OC_RD;
            stpe_pkg::OP_RATIO: begin
              if (col_q >= vc) begin
                res_status <= stpe_pkg::ST_BAD_COL;
                state      <= S_FINISH;
              end else begin
                state <= S_RT_E;
              end
            end
            stpe_pkg::OP_FEAS: state <= S_FS_RD;
            default:           state <= S_FINISH;
          endcase
        end
        S_RD_WAIT: begin
          res_data <= sts.rd_data;
          state    <= S_FINISH;
        end
        S_PV_CHK: begin
          if (sts.rd_data == 32'sd0) begin
            res_status <= stpe_pkg::ST_ZERO_PV;
            state      <= S_FINISH;
          end else begin
            state <= S_PV_ROW;
          end
        end
        // Other rows first, the pivot row last so its old values stay readable.
        S_PV_ROW: begin
          if (!prow && i_q == row_q) begin
            i_q <= i_q + 5'd1;
          end else begin
            j_q   <= '0;
            state <= prow ? S_PV_S : S_PV_C;
          end
        end
        S_PV_C:    state <= S_PV_C2;
        S_PV_C2:   state <= S_PV_S;
        S_PV_S:    state <= (j_q == col_q) ? S_PV_DIV : S_PV_S2;
        S_PV_S2:   state <= prow ? S_PV_RDIV : S_PV_R2;
        S_PV_R2:   state <= S_PV_M;
        S_PV_M:    state <= S_PV_GEN;
        S_PV_GEN:  state <= S_PV_DIV;
        S_PV_RDIV: state <= S_PV_DIV;
        S_PV_DIV: begin
          if (sts.div_done) begin
            if (j_q == vc) begin
              if (prow) begin
                state <= S_FINISH;
              end else if (i_q == cc) begin
                prow  <= 1'b1;
                i_q   <= row_q;
                state <= S_PV_ROW;
              end else begin
                i_q   <= i_q + 5'd1;
                state <= S_PV_ROW;
              end
            end else begin
              j_q   <= j_q + 5'd1;
              state <= S_PV_S;
            end
          end
        end
        // Optimality check: last positive objective entry.
        S_OC_RD:   state <= S_OC_CHK;
        S_OC_CHK: begin
          if (sts.rd_data > 32'sd0) begin
            res_verdict <= stpe_pkg::VD_FOUND;
            res_col     <= j_q;
          end
          if (j_q == vc - 5'd1) begin
            state <= S_FINISH;
          end else begin
            j_q   <= j_q + 5'd1;
            state <= S_OC_RD;
          end
        end
        // Ratio test over constraint rows with a positive entry.
        S_RT_E:    state <= S_RT_E2;
        S_RT_E2: begin
          if (sts.rd_data > 32'sd0) begin
            state <= S_RT_H;
          end else if (rt_next) begin
            state <= S_FINISH;
          end else begin
            i_q   <= i_q + 5'd1;
            state <= S_RT_E;
          end
        end
        S_RT_H:    state <= S_RT_H2;
        S_RT_H2:   state <= S_RT_GO;
        S_RT_GO:   state <= S_RT_DIV;
        S_RT_DIV: begin
          if (sts.div_done) begin
            if (!found || sts.quo_lt_best) begin
              found       <= 1'b1;
              res_verdict <= stpe_pkg::VD_FOUND;
              res_row     <= i_q;
            end
            if (rt_next) begin
              state <= S_FINISH;
            end else begin
              i_q   <= i_q + 5'd1;
              state <= S_RT_E;
            end
          end
        end
        // Feasibility search: last negative RHS row, then its last negative entry.
        S_FS_RD:   state <= S_FS_CHK;
        S_FS_CHK: begin
          if (sts.rd_data < 32'sd0) begin
            found <= 1'b1;
            nrow  <= i_q;
          end
          if (rt_next) begin
            if (found || sts.rd_data < 32'sd0) begin
              res_verdict <= stpe_pkg::VD_INFEASIBLE;
              j_q         <= '0;
              state       <= S_FS_CRD;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            i_q   <= i_q + 5'd1;
            state <= S_FS_RD;
          end
        end
        S_FS_CRD:  state <= S_FS_CCHK;
        S_FS_CCHK: begin
          if (sts.rd_data < 32'sd0) begin
            res_verdict <= stpe_pkg::VD_FOUND;
            res_row     <= nrow;
            res_col     <= j_q;
          end
          if (j_q == vc - 5'd1) begin
            state <= S_FINISH;
          end else begin
            j_q   <= j_q + 5'd1;
            state <= S_FS_CRD;
          end
        end
        // Hand the result to the output register once it is free.
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            verdict    <= res_verdict;
            chosen_row <= res_row;
            chosen_col <= res_col;
            read_data  <= res_data;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/simplex_tableau_pivot_engine.sv
// Simplex tableau engine on signed Q16.16 entries.
// Input channel (in_valid/in_ready) carries one operation per beat: write,
// read, pivot, optimality check, ratio test or feasibility search. Output
// channel (out_valid/out_ready) returns exactly one result beat per input.
// Configuration (cfg_we, cfg_index, cfg_data) sets the column and row counts
// and must be written only while the engine is idle; this is not enforced.
// One operation is in flight at a time. The optimality check and the
// feasibility search read one scanned entry after another. The ratio test
// and the pivot go through one shared 64-step restoring divider, once per
// positive row in the ratio test and once per tableau entry in a pivot.
// Reset clears the sequencer and the output beat and restores 2 variables
// and 1 constraint row; tableau contents are undefined until written.
// A finished result waits in the output register while out_ready is low;
// the engine then accepts the next item but holds its result until the
// register is free.
module simplex_tableau_pivot_engine #(
  parameter int MAX_VARS        = 16,
  parameter int MAX_CONSTRAINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [4:0]         row_index,
  input  logic [4:0]         col_index,
  input  logic signed [31:0] entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [1:0]         verdict,
  output logic [4:0]         chosen_row,
  output logic [4:0]         chosen_col,
  output logic signed [31:0] read_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  stpe_pkg::cmd_t cmd;
  stpe_pkg::sts_t sts;

  // Sequencer.
  stpe_ctrl #(
    .MAX_VARS        (MAX_VARS),
    .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .verdict     (verdict),
    .chosen_row  (chosen_row),
    .chosen_col  (chosen_col),
    .read_data   (read_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Tableau memory, multiplier and divider.
  stpe_datapath #(
    .MAX_VARS        (MAX_VARS),
    .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
